### src/ppfm_pkg.sv
// ----------------------------------------------------------------------------
// ppfm_pkg
// Shared types and constants of the perspective forward map.
// ----------------------------------------------------------------------------
package ppfm_pkg;

    localparam int QBITS  = 14;   // destination coordinate bits
    localparam int MAG_W  = 48;   // magnitude of u, v, w
    localparam int CMP_W  = MAG_W + QBITS;
    localparam int MAX_OUT_DIM = 16384;

    localparam logic [2:0] REG_PAIR_A = 3'd0;
    localparam logic [2:0] REG_PAIR_B = 3'd1;
    localparam logic [2:0] REG_PAIR_C = 3'd2;
    localparam logic [2:0] REG_PAIR_D = 3'd3;
    localparam logic [2:0] REG_LAST   = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;

    typedef struct packed {
        logic signed [31:0] h00, h01, h02;
        logic signed [31:0] h10, h11, h12;
        logic signed [31:0] h20, h21, h22;
    } t_coef;

    typedef struct packed {
        logic [MAG_W-1:0] rem_u;
        logic [MAG_W-1:0] rem_v;
        logic [MAG_W-1:0] den;
        logic [QBITS-1:0] q_u;
        logic [QBITS-1:0] q_v;
        logic             neg_u;
        logic             neg_v;
        logic             ovf_u;
        logic             ovf_v;
        logic             w_zero;
        logic [7:0]       pixel;
    } t_div;

endpackage

### src/ppfm_front.sv
// ----------------------------------------------------------------------------
// ppfm_front
// Products, sums and magnitudes of u, v, w; three registered stages.
// ----------------------------------------------------------------------------
module ppfm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppfm_pkg::t_coef i_coef,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [11:0]     i_row,
    input  logic [11:0]     i_col,
    input  logic [7:0]      i_pixel,
    output logic            o_valid,
    input  logic            i_ready,
    output ppfm_pkg::t_div  o_data
);
    localparam int MW = ppfm_pkg::MAG_W;
    localparam int QB = ppfm_pkg::QBITS;

    logic               r_v1, r_v2, r_v3;
    logic               rdy1, rdy2, rdy3;
    logic signed [44:0] r_p0, r_p1, r_p3, r_p4, r_p6, r_p7;
    logic signed [31:0] r_c2, r_c5, r_c8;
    logic [7:0]         r_pix1, r_pix2;
    logic signed [MW-1:0] r_u, r_v, r_w;
    ppfm_pkg::t_div     r_d3;
    ppfm_pkg::t_div     n_d3;
    logic signed [12:0] row_s, col_s;
    logic [ppfm_pkg::CMP_W-1:0] lim;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_d3;

    assign row_s = signed'({1'b0, i_row});
    assign col_s = signed'({1'b0, i_col});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_p0   <= 45'(i_coef.h00) * 45'(row_s);
            r_p1   <= 45'(i_coef.h01) * 45'(col_s);
            r_p3   <= 45'(i_coef.h10) * 45'(row_s);
            r_p4   <= 45'(i_coef.h11) * 45'(col_s);
            r_p6   <= 45'(i_coef.h20) * 45'(row_s);
            r_p7   <= 45'(i_coef.h21) * 45'(col_s);
            r_c2   <= i_coef.h02;
            r_c5   <= i_coef.h12;
            r_c8   <= i_coef.h22;
            r_pix1 <= i_pixel;
        end
        if (rdy2) begin
            r_u    <= MW'(r_p0) + MW'(r_p1) + MW'(r_c2);
            r_v    <= MW'(r_p3) + MW'(r_p4) + MW'(r_c5);
            r_w    <= MW'(r_p6) + MW'(r_p7) + MW'(r_c8);
            r_pix2 <= r_pix1;
        end
        if (rdy3) r_d3 <= n_d3;
    end

    always_comb begin
        n_d3.rem_u  = r_u[MW-1] ? MW'(-r_u) : MW'(r_u);
        n_d3.rem_v  = r_v[MW-1] ? MW'(-r_v) : MW'(r_v);
        n_d3.den    = r_w[MW-1] ? MW'(-r_w) : MW'(r_w);
        n_d3.neg_u  = r_u[MW-1] ^ r_w[MW-1];
        n_d3.neg_v  = r_v[MW-1] ^ r_w[MW-1];
        n_d3.w_zero = (r_w == '0);
        n_d3.q_u    = '0;
        n_d3.q_v    = '0;
        n_d3.pixel  = r_pix2;
        // quotient at or above 2^QBITS never fits the destination
        lim         = {n_d3.den, {QB{1'b0}}};
        n_d3.ovf_u  = {{QB{1'b0}}, n_d3.rem_u} >= lim;
        n_d3.ovf_v  = {{QB{1'b0}}, n_d3.rem_v} >= lim;
    end
endmodule

### src/ppfm_div_cell.sv
// ----------------------------------------------------------------------------
// ppfm_div_cell
// One restoring division step for u/w and v/w; one quotient bit each.
// ----------------------------------------------------------------------------
module ppfm_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ppfm_pkg::t_div i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ppfm_pkg::t_div o_data
);
    localparam int MW = ppfm_pkg::MAG_W;
    localparam int CW = ppfm_pkg::CMP_W;

    logic           r_valid;
    ppfm_pkg::t_div r_data;
    ppfm_pkg::t_div n_data;
    logic [CW-1:0]  sh;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        sh     = CW'(i_data.den) << SHIFT;
        if (CW'(i_data.rem_u) >= sh) begin
            n_data.rem_u     = MW'(CW'(i_data.rem_u) - sh);
            n_data.q_u[SHIFT] = 1'b1;
        end
        if (CW'(i_data.rem_v) >= sh) begin
            n_data.rem_v     = MW'(CW'(i_data.rem_v) - sh);
            n_data.q_v[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_data <= n_data;
    end
endmodule

### src/perspective_pixel_forward_map.sv
// ----------------------------------------------------------------------------
// perspective_pixel_forward_map
// Forward maps source pixels through a Q16.16 homography to destination writes.
// ----------------------------------------------------------------------------
// One word in, one word out per clock while the output is not stalled. The path
// runs through three stages of multiply, sum and magnitude, a chain of 14 division
// cells that each settle one quotient bit of u/w and v/w, and the output register.
// Stalls on the output side back up through the chain; empty stages still fill.
module perspective_pixel_forward_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // src_row[11:0], src_col[23:12], pixel_in[31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // dest_row[13:0], dest_col[27:14], pixel_out[35:28]
    output logic        m_axis_tuser    // write_enable
);
    localparam int QB = ppfm_pkg::QBITS;

    logic [63:0] r_pair_a, r_pair_b, r_pair_c, r_pair_d;
    logic [31:0] r_last;
    logic [14:0] r_height, r_width;
    logic [2:0]  idx;
    ppfm_pkg::t_coef coef;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_a <= 64'h0001_0000_0000_0000;
            r_pair_b <= '0;
            r_pair_c <= 64'h0001_0000_0000_0000;
            r_pair_d <= '0;
            r_last   <= 32'h0001_0000;
            r_height <= 15'(ppfm_pkg::MAX_OUT_DIM);
            r_width  <= 15'(ppfm_pkg::MAX_OUT_DIM);
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                ppfm_pkg::REG_PAIR_A: r_pair_a <= pwdata;
                ppfm_pkg::REG_PAIR_B: r_pair_b <= pwdata;
                ppfm_pkg::REG_PAIR_C: r_pair_c <= pwdata;
                ppfm_pkg::REG_PAIR_D: r_pair_d <= pwdata;
                ppfm_pkg::REG_LAST:   r_last   <= pwdata[31:0];
                ppfm_pkg::REG_HEIGHT: r_height <= pwdata[14:0];
                ppfm_pkg::REG_WIDTH:  r_width  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ppfm_pkg::REG_PAIR_A: prdata = r_pair_a;
            ppfm_pkg::REG_PAIR_B: prdata = r_pair_b;
            ppfm_pkg::REG_PAIR_C: prdata = r_pair_c;
            ppfm_pkg::REG_PAIR_D: prdata = r_pair_d;
            ppfm_pkg::REG_LAST:   prdata = {32'b0, r_last};
            ppfm_pkg::REG_HEIGHT: prdata = {49'b0, r_height};
            ppfm_pkg::REG_WIDTH:  prdata = {49'b0, r_width};
            default:              prdata = '0;
        endcase
    end

    assign coef.h00 = signed'(r_pair_a[63:32]);
    assign coef.h01 = signed'(r_pair_a[31:0]);
    assign coef.h02 = signed'(r_pair_b[63:32]);
    assign coef.h10 = signed'(r_pair_b[31:0]);
    assign coef.h11 = signed'(r_pair_c[63:32]);
    assign coef.h12 = signed'(r_pair_c[31:0]);
    assign coef.h20 = signed'(r_pair_d[63:32]);
    assign coef.h21 = signed'(r_pair_d[31:0]);
    assign coef.h22 = signed'(r_last);

    ppfm_pkg::t_div d   [QB+1];
    logic           vld [QB+1];
    logic           rdy [QB+1];

    ppfm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_row   (s_axis_tdata[11:0]),
        .i_col   (s_axis_tdata[23:12]),
        .i_pixel (s_axis_tdata[31:24]),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_data  (d[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_cell
        ppfm_div_cell #(.SHIFT(QB - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_data  (d[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_data  (d[k+1])
        );
    end

    // bounds and sign screen, then the output register
    logic [14:0] bound_h, bound_w;
    logic        ok;
    logic        r_out_valid;
    logic        r_we;
    logic [13:0] r_row, r_col;
    logic [7:0]  r_pix;
    ppfm_pkg::t_div df;

    assign df      = d[QB];
    assign bound_h = (r_height > 15'(ppfm_pkg::MAX_OUT_DIM)) ?
                     15'(ppfm_pkg::MAX_OUT_DIM) : r_height;
    assign bound_w = (r_width > 15'(ppfm_pkg::MAX_OUT_DIM)) ?
                     15'(ppfm_pkg::MAX_OUT_DIM) : r_width;
    assign ok = !df.w_zero && !df.ovf_u && !df.ovf_v
             && (!df.neg_u || df.q_u == '0) && (!df.neg_v || df.q_v == '0)
             && ({1'b0, df.q_u} < bound_h) && ({1'b0, df.q_v} < bound_w);
    assign rdy[QB] = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy[QB]) begin
            r_out_valid <= vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[QB]) begin
            r_we  <= ok;
            r_row <= ok ? df.q_u : '0;
            r_col <= ok ? df.q_v : '0;
            r_pix <= ok ? df.pixel : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_we;
    assign m_axis_tdata  = {4'b0, r_pix, r_col, r_row};

    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("null write carries data");
    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
        ({1'b0, m_axis_tdata[13:0]} < bound_h) && ({1'b0, m_axis_tdata[27:14]} < bound_w))
        else $error("write outside destination");
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

### tb/sv/perspective_pixel_forward_map_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perspective_pixel_forward_map_tb
// Streams source pixels through several homographies and destination sizes,
// predicts every destination write and checks each output word against it.
// ----------------------------------------------------------------------------
module perspective_pixel_forward_map_tb;

    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 18;

    typedef struct packed {
        logic        wen;
        logic [13:0] drow;
        logic [13:0] dcol;
        logic [7:0]  pix;
    } t_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // src_row[11:0], src_col[23:12], pixel_in[31:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // dest_row[13:0], dest_col[27:14], pixel_out[35:28]
    logic        m_axis_tuser;        // write_enable

    perspective_pixel_forward_map uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the mapping registers
    logic signed [31:0] hc [9];
    logic [14:0] ht_reg, wd_reg;
    logic [31:0] pixel_q [$];
    t_write      write_q [$];
    int errors = 0;
    int idle_pct = 0, stall_pct = 0;
    int quiet = 0;
    logic hold_src = 1'b0;

    function automatic void add_pixel(logic [31:0] word);
        pixel_q.insert(pixel_q.size(), word);
    endfunction

    function automatic t_write map_pixel(logic [31:0] word);
        longint r, c, u, v, w, qu, qv, hb, wb;
        t_write res;
        r = word[11:0];
        c = word[23:12];
        res = '0;
        u = longint'(hc[0]) * r + longint'(hc[1]) * c + longint'(hc[2]);
        v = longint'(hc[3]) * r + longint'(hc[4]) * c + longint'(hc[5]);
        w = longint'(hc[6]) * r + longint'(hc[7]) * c + longint'(hc[8]);
        if (w == 0) return res;
        qu = u / w;
        qv = v / w;
        hb = (ht_reg > ppfm_pkg::MAX_OUT_DIM) ? ppfm_pkg::MAX_OUT_DIM : ht_reg;
        wb = (wd_reg > ppfm_pkg::MAX_OUT_DIM) ? ppfm_pkg::MAX_OUT_DIM : wd_reg;
        if (qu < 0 || qv < 0 || qu >= hb || qv >= wb) return res;
        res.wen = 1'b1;
        res.drow = qu[13:0];
        res.dcol = qv[13:0];
        res.pix = word[31:24];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ppfm_pkg::REG_PAIR_A: begin hc[0] = val[63:32]; hc[1] = val[31:0]; end
            ppfm_pkg::REG_PAIR_B: begin hc[2] = val[63:32]; hc[3] = val[31:0]; end
            ppfm_pkg::REG_PAIR_C: begin hc[4] = val[63:32]; hc[5] = val[31:0]; end
            ppfm_pkg::REG_PAIR_D: begin hc[6] = val[63:32]; hc[7] = val[31:0]; end
            ppfm_pkg::REG_LAST:   hc[8] = val[31:0];
            ppfm_pkg::REG_HEIGHT: ht_reg = val[14:0];
            ppfm_pkg::REG_WIDTH:  wd_reg = val[14:0];
            default: ;
        endcase
    endtask

    task automatic load_map(logic signed [31:0] a, b, e, f, g, h, p, q, s,
                            logic [14:0] ht, wd);
        reg_write(ppfm_pkg::REG_PAIR_A, {a, b});
        reg_write(ppfm_pkg::REG_PAIR_B, {e, f});
        reg_write(ppfm_pkg::REG_PAIR_C, {g, h});
        reg_write(ppfm_pkg::REG_PAIR_D, {p, q});
        reg_write(ppfm_pkg::REG_LAST, {32'd0, s});
        reg_write(ppfm_pkg::REG_HEIGHT, {49'd0, ht});
        reg_write(ppfm_pkg::REG_WIDTH, {49'd0, wd});
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && !s_axis_tvalid);
        wait (write_q.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_pixel();
        return $urandom;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                write_q.insert(write_q.size(), map_pixel(s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_q.size() != 0 && !hold_src &&
                    $urandom_range(99) >= idle_pct) begin
                    s_axis_tdata <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_write want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet > WATCHDOG) begin
                $display("perspective_pixel_forward_map_tb failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (write_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata, 0);
                end else begin
                    want = write_q.pop_front();
                    if (m_axis_tuser !== want.wen)
                        report_mismatch("write_enable", m_axis_tuser, want.wen);
                    if (m_axis_tdata[13:0] !== want.drow)
                        report_mismatch("dest_row", m_axis_tdata[13:0], want.drow);
                    if (m_axis_tdata[27:14] !== want.dcol)
                        report_mismatch("dest_col", m_axis_tdata[27:14], want.dcol);
                    if (m_axis_tdata[35:28] !== want.pix)
                        report_mismatch("pixel_out", m_axis_tdata[35:28], want.pix);
                end
            end
        end
    end

    initial begin
        int ph;
        logic signed [31:0] k [9];
        hc[0] = 32'sh10000; hc[1] = 0; hc[2] = 0; hc[3] = 0; hc[4] = 32'sh10000;
        hc[5] = 0; hc[6] = 0; hc[7] = 0; hc[8] = 32'sh10000;
        ht_reg = 15'd16384; wd_reg = 15'd16384;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset: corners and pixel extremes
        add_pixel({8'h00, 12'd0, 12'd0});
        add_pixel({8'hff, 12'hfff, 12'hfff});
        add_pixel({8'h5a, 12'hfff, 12'd0});
        add_pixel({8'ha5, 12'd0, 12'hfff});
        drain();
        // zero w everywhere
        load_map(32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 0, 15'd16384, 15'd16384);
        add_pixel({8'h11, 12'd7, 12'd9});
        add_pixel({8'h22, 12'd0, 12'd0});
        drain();
        // small negative quotients truncate to zero
        load_map(-32'sd1, 0, 0, 0, -32'sd1, 0, 0, 0, 32'sh10000, 15'd1, 15'd1);
        add_pixel({8'h33, 12'd5, 12'd5});
        add_pixel({8'h44, 12'd0, 12'd0});
        drain();
        // extreme coefficients, oversize bounds clamp, zero bounds
        load_map(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 15'h7fff, 15'h7fff);
        for (int i = 0; i < 6; i++) add_pixel(rnd_pixel());
        drain();
        load_map(32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh4000, 15'd0, 15'd0);
        for (int i = 0; i < 4; i++) add_pixel(rnd_pixel());
        drain();

        for (ph = 0; ph < 12; ph++) begin
            // mostly near-identity maps scaled so many pixels land inside
            for (int j = 0; j < 9; j++) k[j] = $urandom;
            if (ph % 3 != 2) begin
                k[0] = $urandom_range(32768, 131072);
                k[1] = $signed($urandom_range(0, 16384)) - 8192;
                k[2] = $urandom_range(0, 1 << 26);
                k[3] = $signed($urandom_range(0, 16384)) - 8192;
                k[4] = $urandom_range(32768, 131072);
                k[5] = $urandom_range(0, 1 << 26);
                k[6] = $urandom_range(0, 16);
                k[7] = $urandom_range(0, 16);
                k[8] = $urandom_range(32768, 131072);
            end
            load_map(k[0], k[1], k[2], k[3], k[4], k[5], k[6], k[7], k[8],
                     (ph == 5) ? 15'd1 : 15'($urandom_range(1, 16384)),
                     (ph == 7) ? 15'd16384 : 15'($urandom_range(1, 20000)));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            for (int i = 0; i < 62; i++) add_pixel(rnd_pixel());
            if (ph == 3) begin
                // pause the source until the pipeline is empty
                wait (pixel_q.size() < 30);
                hold_src = 1'b1;
                wait (write_q.size() == 0 && !m_axis_tvalid);
                hold_src = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("perspective_pixel_forward_map_tb passed");
        else
            $display("perspective_pixel_forward_map_tb failed");
        $finish;
    end
endmodule

### files.f
src/ppfm_pkg.sv
src/ppfm_front.sv
src/ppfm_div_cell.sv
src/perspective_pixel_forward_map.sv
tb/sv/perspective_pixel_forward_map_tb.sv
